// ===== rtl/omm_pkg.sv =====
// ----------------------------------------------------------------------------
// omm_pkg: shared types and constants for the overlapping match merger
// Widths, reset values, the queue entry passed from front to back, the
// result record and the back-end state encoding.
// ----------------------------------------------------------------------------
package omm_pkg;

  localparam int COORD_BITS = 32;
  localparam int ID_BITS    = 16;
  localparam int SCORE_BITS = 16;
  localparam int CNT_BITS   = 16;

  localparam logic [CNT_BITS-1:0]   CNT_MAX         = '1;
  localparam logic [SCORE_BITS-1:0] MIN_SCORE_RESET = SCORE_BITS'(39322);

  // classified-item queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  // one classified match, with its end sums worked out by the front
  typedef struct packed {
    logic                  keep;
    logic                  last;
    logic [ID_BITS-1:0]    tid;
    logic [ID_BITS-1:0]    qid;
    logic                  rev;
    logic [COORD_BITS-1:0] ts;
    logic [COORD_BITS-1:0] qs;
    logic [COORD_BITS-1:0] qlen;
    logic [COORD_BITS:0]   tend;   // ts + len, full precision
    logic [COORD_BITS:0]   qend;   // qs + len, full precision
    logic [COORD_BITS+1:0] qdiff;  // qs - ts, two's complement
  } omm_entry_t;

  typedef struct packed {
    logic [ID_BITS-1:0]    tid;
    logic [ID_BITS-1:0]    qid;
    logic                  rev;
    logic [COORD_BITS-1:0] tbeg;
    logic [COORD_BITS-1:0] tend;
    logic [COORD_BITS-1:0] qbeg;
    logic [COORD_BITS-1:0] qend;
    logic [CNT_BITS-1:0]   count;
    logic                  last;
  } omm_result_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'b01,
    ST_FLUSH = 2'b10
  } omm_state_t;

endpackage

// ===== rtl/overlapping_match_merge.sv =====
// ----------------------------------------------------------------------------
// overlapping_match_merge: merge sorted alignment matches into runs
// Filters matches by score, joins overlapping matches with equal keys into
// runs and emits one record per run, query coordinates mirrored on the reverse strand.
// ----------------------------------------------------------------------------
//
//   channel   handshake               transaction
//   -------   ---------------------   ----------------------------------------
//   input     in_valid / in_ready     one match (ids, strand, coords, score)
//   output    out_valid / out_ready   one merged run record
//   config    cfg_wr_en               score threshold write, no wait
//
// One match per cycle sustained while the output does not stall; the back end
// does one join compare and one end add per cycle against the open-run
// registers. A kept match that carries last_item is handled in the merge,
// then in the flush state. Matches reach the result register via the queue.
// Synchronous reset clears the queue, the open-run flag and the result
// valid flag; the threshold returns to 0.6. Either side may stall: the
// two-entry queue decouples input ready from the result register.
// ----------------------------------------------------------------------------
module overlapping_match_merge import omm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [SCORE_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ID_BITS-1:0]    target_id,
  input  logic [ID_BITS-1:0]    query_id,
  input  logic                  reverse_strand,
  input  logic [COORD_BITS-1:0] target_start,
  input  logic [COORD_BITS-1:0] query_start,
  input  logic [COORD_BITS-1:0] match_length,
  input  logic [COORD_BITS-1:0] query_length,
  input  logic [SCORE_BITS-1:0] score,
  input  logic                  last_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_BITS-1:0]    out_target_id,
  output logic [ID_BITS-1:0]    out_query_id,
  output logic                  out_reverse,
  output logic [COORD_BITS-1:0] target_begin,
  output logic [COORD_BITS-1:0] target_end,
  output logic [COORD_BITS-1:0] query_begin,
  output logic [COORD_BITS-1:0] query_end,
  output logic [CNT_BITS-1:0]   blocks_merged,
  output logic                  last_result
);

  // front to queue
  logic        push;
  logic        push_ready;
  omm_entry_t  push_entry;
  // queue to back
  logic        head_valid;
  logic        head_pop;
  omm_entry_t  head_entry;
  // back result register
  omm_result_t res;

  // classify: drop weak matches, precompute end sums
  omm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_id      (target_id),
    .query_id       (query_id),
    .reverse_strand (reverse_strand),
    .target_start   (target_start),
    .query_start    (query_start),
    .match_length   (match_length),
    .query_length   (query_length),
    .score          (score),
    .last_item      (last_item),
    .q_ready        (push_ready),
    .q_push         (push),
    .q_entry        (push_entry)
  );

  // hold classified matches until the back end takes them
  omm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .wr_ready (push_ready),
    .pop      (head_pop),
    .rd_valid (head_valid),
    .rd_entry (head_entry)
  );

  // merge into the open run and emit finished runs
  omm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_entry   (head_entry),
    .q_pop     (head_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // unpack the result record onto the ports
  assign out_target_id = res.tid;
  assign out_query_id  = res.qid;
  assign out_reverse   = res.rev;
  assign target_begin  = res.tbeg;
  assign target_end    = res.tend;
  assign query_begin   = res.qbeg;
  assign query_end     = res.qend;
  assign blocks_merged = res.count;
  assign last_result   = res.last;

endmodule

// ===== rtl/omm_front.sv =====
// ----------------------------------------------------------------------------
// omm_front: score filter and classifier
// Holds the threshold register, drops weak matches and precomputes the
// end sums so the back end needs one add per join.
// ----------------------------------------------------------------------------
module omm_front import omm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [SCORE_BITS-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ID_BITS-1:0]    target_id,
  input  logic [ID_BITS-1:0]    query_id,
  input  logic                  reverse_strand,
  input  logic [COORD_BITS-1:0] target_start,
  input  logic [COORD_BITS-1:0] query_start,
  input  logic [COORD_BITS-1:0] match_length,
  input  logic [COORD_BITS-1:0] query_length,
  input  logic [SCORE_BITS-1:0] score,
  input  logic                  last_item,
  input  logic                  q_ready,
  output logic                  q_push,
  output omm_entry_t            q_entry
);

  logic [SCORE_BITS-1:0] score_limit;
  logic                  keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_limit <= MIN_SCORE_RESET;
    end else if (cfg_wr_en) begin
      score_limit <= cfg_wr_data;
    end
  end

  assign keep     = score > score_limit;
  assign in_ready = q_ready;
  // drop weak matches unless they carry the end-of-stream mark
  assign q_push   = in_valid && q_ready && (keep || last_item);

  always_comb begin
    q_entry.keep  = keep;
    q_entry.last  = last_item;
    q_entry.tid   = target_id;
    q_entry.qid   = query_id;
    q_entry.rev   = reverse_strand;
    q_entry.ts    = target_start;
    q_entry.qs    = query_start;
    q_entry.qlen  = query_length;
    q_entry.tend  = {1'b0, target_start} + {1'b0, match_length};
    q_entry.qend  = {1'b0, query_start} + {1'b0, match_length};
    q_entry.qdiff = {2'b00, query_start} - {2'b00, target_start};
  end

endmodule

// ===== rtl/omm_queue.sv =====
// ----------------------------------------------------------------------------
// omm_queue: short queue of classified matches
// Two-entry FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module omm_queue import omm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  omm_entry_t wr_entry,
  output logic       wr_ready,
  input  logic       pop,
  output logic       rd_valid,
  output omm_entry_t rd_entry
);

  omm_entry_t           mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign wr_ready = count < QCNT_BITS'(QDEPTH);
  assign rd_valid = count != '0;
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/omm_back.sv =====
// ----------------------------------------------------------------------------
// omm_back: run merger and result register
// Joins queued matches into the open run, emits finished runs and flushes
// at end of stream. A kept item that ends the stream is merged first and then
// handled in the flush state.
// ----------------------------------------------------------------------------
module omm_back import omm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  omm_entry_t  q_entry,
  output logic        q_pop,
  output logic        res_valid,
  input  logic        res_ready,
  output omm_result_t res
);

  omm_state_t state;
  omm_state_t state_next;

  logic                  run_open;
  logic [ID_BITS-1:0]    run_tid;
  logic [ID_BITS-1:0]    run_qid;
  logic                  run_rev;
  logic [COORD_BITS-1:0] run_first_ts;
  logic [COORD_BITS-1:0] run_first_qs;
  logic [COORD_BITS-1:0] lat_ts;
  logic [COORD_BITS-1:0] lat_qs;
  logic [COORD_BITS:0]   run_tend;
  logic [COORD_BITS:0]   run_qend;
  logic [COORD_BITS-1:0] run_qlen;
  logic [CNT_BITS-1:0]   run_count;

  logic                  joins;
  logic                  keep_old_end;
  logic [COORD_BITS+1:0] qend_stretch;
  logic                  emit_req;
  logic                  emit_last;
  logic                  do_join;
  logic                  do_open;
  logic                  do_close;
  logic                  pop_req;
  logic                  go;
  omm_result_t           emit;

  always_comb begin
    joins = run_open && q_entry.tid == run_tid && q_entry.qid == run_qid &&
            q_entry.rev == run_rev && q_entry.ts >= lat_ts && q_entry.qs >= lat_qs &&
            {1'b0, q_entry.ts} < run_tend && {1'b0, q_entry.qs} < run_qend;
    keep_old_end = q_entry.tend < run_tend;
    qend_stretch = q_entry.qdiff + {1'b0, run_tend};
  end

  always_comb begin
    emit_req   = 1'b0;
    emit_last  = 1'b0;
    do_join    = 1'b0;
    do_open    = 1'b0;
    do_close   = 1'b0;
    pop_req    = 1'b0;
    state_next = state;
    unique case (state)
      ST_MATCH: begin
        if (q_entry.keep) begin
          if (joins) begin
            do_join = 1'b1;
          end else begin
            do_open  = 1'b1;
            emit_req = run_open;
          end
          if (q_entry.last) begin
            state_next = ST_FLUSH;
          end else begin
            pop_req = 1'b1;
          end
        end else begin
          pop_req = 1'b1;
          if (q_entry.last) begin
            emit_req  = run_open;
            emit_last = 1'b1;
            do_close  = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        emit_req   = run_open;
        emit_last  = 1'b1;
        do_close   = 1'b1;
        pop_req    = 1'b1;
        state_next = ST_MATCH;
      end
      default: begin
        state_next = ST_MATCH;
      end
    endcase
    go = q_valid && (!emit_req || !res_valid || res_ready);
  end

  assign q_pop = go && pop_req;

  // result fields of the open run, query coordinates mirrored on the reverse strand
  always_comb begin
    emit.tid   = run_tid;
    emit.qid   = run_qid;
    emit.rev   = run_rev;
    emit.tbeg  = run_first_ts;
    emit.tend  = run_tend[COORD_BITS] ? '1 : run_tend[COORD_BITS-1:0];
    emit.count = run_count;
    emit.last  = emit_last;
    if (run_rev) begin
      emit.qbeg = ({1'b0, run_qlen} > run_qend) ?
                  COORD_BITS'({1'b0, run_qlen} - run_qend) : '0;
      emit.qend = (run_qlen > run_first_qs) ? run_qlen - run_first_qs : '0;
    end else begin
      emit.qbeg = run_first_qs;
      emit.qend = run_qend[COORD_BITS] ? '1 : run_qend[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_MATCH;
      run_open  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (q_valid && go) begin
        state <= state_next;
      end
      if (go && do_open) begin
        run_open <= 1'b1;
      end else if (go && do_close) begin
        run_open <= 1'b0;
      end
      if (go && emit_req) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit_req) begin
      res <= emit;
    end
    if (go && do_open) begin
      run_tid      <= q_entry.tid;
      run_qid      <= q_entry.qid;
      run_rev      <= q_entry.rev;
      run_first_ts <= q_entry.ts;
      run_first_qs <= q_entry.qs;
      lat_ts       <= q_entry.ts;
      lat_qs       <= q_entry.qs;
      run_tend     <= q_entry.tend;
      run_qend     <= q_entry.qend;
      run_qlen     <= q_entry.qlen;
      run_count    <= CNT_BITS'(1);
    end else if (go && do_join) begin
      lat_ts   <= q_entry.ts;
      lat_qs   <= q_entry.qs;
      run_tend <= keep_old_end ? run_tend : q_entry.tend;
      run_qend <= keep_old_end ? qend_stretch[COORD_BITS:0] : q_entry.qend;
      if (run_count != CNT_MAX) begin
        run_count <= run_count + 1'b1;
      end
    end
  end

  a_flush_has_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> run_open)
    else $error("flush state entered with no open run");

  a_flush_has_item: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> q_valid)
    else $error("flush state without its queued item");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    run_open |-> run_count != '0)
    else $error("open run with zero members");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (go && emit_req && emit_last) |=> !run_open)
    else $error("run still open after final result");

endmodule
